>>> hw/rtl/npr_pkg.sv
// Shared widths, constants and divider handshake types for the prime run search.
`default_nettype none

package npr_pkg;

	localparam int START_W  = 32;
	localparam int PRIME_W  = 31;
	localparam int IDX_W    = 6;
	localparam int CNT_W    = 7;
	localparam int SUM_W    = 37;
	localparam int MEAN_W   = 39;
	localparam int FRAC_W   = 8;
	localparam int DIV_NW   = SUM_W + FRAC_W;
	localparam int DIV_DW   = 16;
	localparam int DIV_SW   = 6;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] dividend;
		logic [DIV_DW-1:0] divisor;
		logic [DIV_SW-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quotient;
		logic [DIV_DW-1:0] remainder;
	} div_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/npr_if.sv
// Valid/ready channel interfaces for start values and prime results.
`default_nettype none

interface npr_in_if;
	import npr_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [START_W-1:0] start_value;

	modport source (output valid, output start_value, input ready);
	modport sink   (input valid, input start_value, output ready);
endinterface

interface npr_out_if;
	import npr_pkg::*;

	logic               valid;
	logic               ready;
	logic [PRIME_W-1:0] prime_value;
	logic [IDX_W-1:0]   run_index;
	logic               is_last;
	logic [SUM_W-1:0]   prime_sum;
	logic [MEAN_W-1:0]  mean_q8;
	logic               overflow;

	modport source (output valid, output prime_value, output run_index, output is_last,
		output prime_sum, output mean_q8, output overflow, input ready);
	modport sink   (input valid, input prime_value, input run_index, input is_last,
		input prime_sum, input mean_q8, input overflow, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/next_primes_run_with_mean.sv
// Top level: prime run search by trial division with running sum and Q.8 mean.
// Throughput: one run at a time; an odd candidate c costs about (sqrt(c)/2) trial
// divisions in the serial remainder unit; other candidates need no trial division.
// The first result follows the first prime found; the last also waits for the mean division.
// A two-entry queue takes start values while a run is in progress.
// Reset: arst_n clears all control state at once; no clearing pass.
`default_nettype none

module next_primes_run_with_mean #(
	parameter int RUN_LENGTH  = 20,
	parameter int VALUE_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	npr_in_if.sink    items,
	npr_out_if.source results
);
	import npr_pkg::*;

	logic                   q_valid;
	logic                   q_ready;
	logic [VALUE_WIDTH-2:0] q_cand;
	div_req_t               div_req;
	div_rsp_t               div_rsp;

	npr_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_cand  (q_cand)
	);

	npr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	npr_back #(
		.RUN_LENGTH (RUN_LENGTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_cand  (q_cand),
		.div_req (div_req),
		.div_rsp (div_rsp),
		.results (results)
	);

endmodule

`default_nettype wire

>>> hw/rtl/npr_front.sv
// Front end: accept start values, clamp them to the first candidate, queue them.
`default_nettype none

module npr_front #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	npr_in_if.sink                 items,
	output logic                   q_valid,
	input  logic                   q_ready,
	output logic [VALUE_WIDTH-2:0] q_cand
);
	import npr_pkg::*;

	localparam int CW = VALUE_WIDTH - 1;

	logic [CW-1:0]          slot_q [2];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             count_q;
	logic [VALUE_WIDTH-1:0] raw;
	logic [CW-1:0]          first;
	logic                   push;
	logic                   pop;

	assign raw   = items.start_value[VALUE_WIDTH-1:0];
	assign first = (raw[VALUE_WIDTH-1] || raw[CW-1:0] < CW'(2)) ? CW'(2) : raw[CW-1:0];

	assign items.ready = (count_q != 2'd2);
	assign q_valid     = (count_q != 2'd0);
	assign q_cand      = slot_q[rd_ptr_q];
	assign push        = items.valid && items.ready;
	assign pop         = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= first;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: begin
					count_q <= count_q + 2'd1;
				end
				2'b01: begin
					count_q <= count_q - 2'd1;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/npr_div.sv
// Shared restoring divider: one quotient bit per cycle, remainder and quotient out.
`default_nettype none

module npr_div (
	input  logic               clk,
	input  logic               arst_n,
	input  npr_pkg::div_req_t  req,
	output npr_pkg::div_rsp_t  rsp
);
	import npr_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DIV_NW-1:0] sh_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] div_q;
	logic [DIV_SW-1:0] cnt_q;
	logic [DIV_DW:0]   partial;
	logic [DIV_DW:0]   diff;
	logic              fits;

	assign partial = {rem_q, sh_q[DIV_NW-1]};
	assign fits    = (partial >= {1'b0, div_q});
	assign diff    = partial - {1'b0, div_q};

	assign rsp.done      = done_q;
	assign rsp.quotient  = sh_q;
	assign rsp.remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sh_q   <= '0;
			rem_q  <= '0;
			div_q  <= '0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			sh_q   <= req.dividend;
			rem_q  <= '0;
			div_q  <= req.divisor;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[DIV_DW-1:0] : partial[DIV_DW-1:0];
			sh_q   <= {sh_q[DIV_NW-2:0], fits};
			cnt_q  <= cnt_q - DIV_SW'(1);
			busy_q <= (cnt_q != DIV_SW'(1));
			done_q <= (cnt_q == DIV_SW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/npr_back.sv
// Back end: walk candidates, test by trial division, accumulate, register results.
`default_nettype none

module npr_back #(
	parameter int RUN_LENGTH  = 20,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	output logic                   q_ready,
	input  logic [VALUE_WIDTH-2:0] q_cand,
	output npr_pkg::div_req_t      div_req,
	input  npr_pkg::div_rsp_t      div_rsp,
	npr_out_if.source              results
);
	import npr_pkg::*;

	localparam int DW = (VALUE_WIDTH + 1) / 2;
	localparam int PW = 2 * DW;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SQUARE,
		ST_DIVIDE,
		ST_PRIME,
		ST_MEAN,
		ST_EMIT
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] cand_q;
	logic [DW-1:0]          d_q;
	logic [CNT_W-1:0]       found_q;
	logic [SUM_W-1:0]       sum_q;
	logic                   last_q;
	logic                   ovf_q;
	div_req_t               div_req_q;

	logic                   out_valid_q;
	logic [PRIME_W-1:0]     prime_value_q;
	logic [IDX_W-1:0]       run_index_q;
	logic                   is_last_q;
	logic [SUM_W-1:0]       prime_sum_q;
	logic [MEAN_W-1:0]      mean_q8_q;
	logic                   overflow_q;

	logic [PW-1:0]          square;
	logic [SUM_W-1:0]       sum_next;
	logic [CNT_W-1:0]       found_next;
	logic                   slot_free;

	assign square     = PW'(d_q) * PW'(d_q);
	assign sum_next   = sum_q + SUM_W'(cand_q);
	assign found_next = found_q + CNT_W'(1);
	assign slot_free  = !out_valid_q || results.ready;
	assign q_ready    = (state_q == ST_IDLE);
	assign div_req    = div_req_q;

	assign results.valid       = out_valid_q;
	assign results.prime_value = prime_value_q;
	assign results.run_index   = run_index_q;
	assign results.is_last     = is_last_q;
	assign results.prime_sum   = prime_sum_q;
	assign results.mean_q8     = mean_q8_q;
	assign results.overflow    = overflow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cand_q        <= '0;
			d_q           <= DW'(3);
			found_q       <= '0;
			sum_q         <= '0;
			last_q        <= 1'b0;
			ovf_q         <= 1'b0;
			div_req_q     <= '0;
			out_valid_q   <= 1'b0;
			prime_value_q <= '0;
			run_index_q   <= '0;
			is_last_q     <= 1'b0;
			prime_sum_q   <= '0;
			mean_q8_q     <= '0;
			overflow_q    <= 1'b0;
		end else begin
			if (out_valid_q && results.ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cand_q  <= {1'b0, q_cand};
						found_q <= '0;
						sum_q   <= '0;
						last_q  <= 1'b0;
						ovf_q   <= 1'b0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (cand_q[VALUE_WIDTH-1]) begin
						ovf_q  <= 1'b1;
						last_q <= 1'b1;
						if (found_q != '0) begin
							div_req_q.start    <= 1'b1;
							div_req_q.dividend <= {sum_q, FRAC_W'(0)};
							div_req_q.divisor  <= DIV_DW'(found_q);
							div_req_q.steps    <= DIV_SW'(DIV_NW);
							state_q            <= ST_MEAN;
						end else begin
							state_q <= ST_EMIT;
						end
					end else if (cand_q == VALUE_WIDTH'(2)) begin
						state_q <= ST_PRIME;
					end else if (!cand_q[0]) begin
						cand_q <= cand_q + VALUE_WIDTH'(1);
					end else begin
						d_q     <= DW'(3);
						state_q <= ST_SQUARE;
					end
				end
				ST_SQUARE: begin
					if (square > PW'(cand_q)) begin
						state_q <= ST_PRIME;
					end else begin
						div_req_q.start    <= 1'b1;
						div_req_q.dividend <= DIV_NW'(cand_q) << (DIV_NW - VALUE_WIDTH + 1);
						div_req_q.divisor  <= DIV_DW'(d_q);
						div_req_q.steps    <= DIV_SW'(VALUE_WIDTH - 1);
						state_q            <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					div_req_q.start <= 1'b0;
					if (div_rsp.done) begin
						if (div_rsp.remainder == '0) begin
							cand_q  <= cand_q + VALUE_WIDTH'(1);
							state_q <= ST_CHECK;
						end else begin
							d_q     <= d_q + DW'(2);
							state_q <= ST_SQUARE;
						end
					end
				end
				ST_PRIME: begin
					sum_q   <= sum_next;
					found_q <= found_next;
					if (found_next >= CNT_W'(RUN_LENGTH)) begin
						last_q             <= 1'b1;
						div_req_q.start    <= 1'b1;
						div_req_q.dividend <= {sum_next, FRAC_W'(0)};
						div_req_q.divisor  <= DIV_DW'(found_next);
						div_req_q.steps    <= DIV_SW'(DIV_NW);
						state_q            <= ST_MEAN;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_MEAN: begin
					div_req_q.start <= 1'b0;
					if (div_rsp.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_valid_q   <= 1'b1;
						prime_value_q <= ovf_q ? '0 : PRIME_W'(cand_q[VALUE_WIDTH-2:0]);
						run_index_q   <= ovf_q ? found_q[IDX_W-1:0]
							: IDX_W'(found_q - CNT_W'(1));
						is_last_q     <= last_q;
						prime_sum_q   <= last_q ? sum_q : '0;
						mean_q8_q     <= (last_q && found_q != '0)
							? div_rsp.quotient[MEAN_W-1:0] : '0;
						overflow_q    <= ovf_q;
						if (last_q) begin
							state_q <= ST_IDLE;
						end else begin
							cand_q  <= cand_q + VALUE_WIDTH'(1);
							state_q <= ST_CHECK;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
